// ===== hdl/bse_pkg.sv =====
// Shared types and codes of the boosted stump ensemble classifier.
// Used by the accumulator, the vote tally and the top level; depends on nothing.
package bse_pkg;

  localparam logic [1:0] REQ_STUMP    = 2'd0;
  localparam logic [1:0] REQ_HEADER   = 2'd1;
  localparam logic [1:0] REQ_CLASSIFY = 2'd2;

  localparam logic [1:0] CFG_METHOD = 2'd0;
  localparam logic [1:0] CFG_NUM    = 2'd1;

  localparam logic METHOD_OVO = 1'b0;
  localparam logic METHOD_OVR = 1'b1;

  localparam logic signed [3:0] LABEL_NONE = -4'sd1;

  localparam int WEIGHT_W = 16;

  typedef struct packed {
    logic [5:0]          feat;
    logic                pol;
    logic [WEIGHT_W-1:0] weight;
  } stump_t;

  typedef struct packed {
    logic [6:0]        count;
    logic [2:0]        pos;
    logic signed [3:0] neg;
  } header_t;

  typedef struct packed {
    logic clr;
    logic en;
    logic sub;
  } acc_ctrl_t;

  typedef struct packed {
    logic       clr;
    logic       en;
    logic [2:0] label;
  } vote_ctrl_t;

endpackage

// ===== hdl/bse_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/bse_acc.sv =====
// Shared add/subtract accumulator for the signed weighted stump sum.
// Depends on bse_pkg.
module bse_acc #(
  parameter int SUM_W = 24
) (
  input  logic                  clk,
  input  bse_pkg::acc_ctrl_t    ctrl,
  input  logic [bse_pkg::WEIGHT_W-1:0] weight,
  output logic                  nonneg
);
  import bse_pkg::*;

  logic signed [SUM_W-1:0] sum_r;
  logic signed [SUM_W-1:0] w_ext;

  assign w_ext = SUM_W'(weight);

  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      sum_r <= '0;
    end else if (ctrl.en) begin
      if (ctrl.sub) begin
        sum_r <= sum_r - w_ext;
      end else begin
        sum_r <= sum_r + w_ext;
      end
    end
  end

  assign nonneg = !sum_r[SUM_W-1];

endmodule

// ===== hdl/bse_vote.sv =====
// One-versus-one vote tally with a running leader (lowest class on ties).
// Depends on bse_pkg.
module bse_vote #(
  parameter int NUM_CLASSES     = 8,
  parameter int MAX_CLASSIFIERS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bse_pkg::vote_ctrl_t ctrl,
  output logic [((NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1)-1:0] best_label
);
  import bse_pkg::*;

  localparam int CLW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int VW  = $clog2(MAX_CLASSIFIERS + 1);

  logic [VW-1:0]  cnt_r [NUM_CLASSES];
  logic [VW-1:0]  best_r;
  logic [CLW-1:0] lbl_r;
  logic [CLW-1:0] idx;
  logic [VW-1:0]  inc;

  assign idx = CLW'(ctrl.label);
  assign inc = cnt_r[idx] + VW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clr) begin
      for (int k = 0; k < NUM_CLASSES; k++) begin
        cnt_r[k] <= '0;
      end
      best_r <= '0;
      lbl_r  <= '0;
    end else if (ctrl.en) begin
      cnt_r[idx] <= inc;
      if (inc > best_r || (inc == best_r && idx < lbl_r)) begin
        best_r <= inc;
        lbl_r  <= idx;
      end
    end
  end

  assign best_label = lbl_r;

endmodule

// ===== hdl/boosted_stump_ensemble_classifier.sv =====
// Top level of the boosted stump ensemble classifier: sequencer, tables, ports.
// Depends on bse_pkg, bse_ram, bse_acc and bse_vote.
//
// A classify transaction walks the classifiers in use one after another through
// a single accumulator fed by the stump RAM read port, one stump per cycle; each
// classifier also passes through header request, header wait and decide states.
// The input stalls while a classify request is in flight; the result sits in an
// output register, so the next transaction is taken while it waits. The stump
// and header tables hold garbage after reset and must be written before use.
module boosted_stump_ensemble_classifier #(
  parameter int MAX_CLASSIFIERS = 16,
  parameter int MAX_STUMPS      = 64,
  parameter int NUM_FEATURES    = 64,
  parameter int NUM_CLASSES     = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_req_type,
  input  logic [3:0]         in_classifier_index,
  input  logic [5:0]         in_stump_index,
  input  logic [5:0]         in_feature_index,
  input  logic               in_polarity,
  input  logic [15:0]        in_stump_weight,
  input  logic [6:0]         in_stump_count,
  input  logic [2:0]         in_positive_label,
  input  logic signed [3:0]  in_negative_label,
  input  logic [63:0]        in_feature_bits,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [3:0]  out_predicted_label,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [4:0]         cfg_wdata
);
  import bse_pkg::*;

  localparam int CW    = (MAX_CLASSIFIERS > 1) ? $clog2(MAX_CLASSIFIERS) : 1;
  localparam int SW    = (MAX_STUMPS > 1) ? $clog2(MAX_STUMPS) : 1;
  localparam int CCW   = $clog2(MAX_CLASSIFIERS + 1);
  localparam int SCW   = $clog2(MAX_STUMPS + 1);
  localparam int FW    = $clog2(NUM_FEATURES);
  localparam int CLW   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int SUM_W = SW + WEIGHT_W + 2;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_HREQ   = 3'd1;
  localparam logic [2:0] S_HWAIT  = 3'd2;
  localparam logic [2:0] S_RUN    = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;
  localparam logic [2:0] S_TALLY  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]              state_r, state_nxt;
  logic                    method_r;
  logic [4:0]              num_r;
  logic                    meth_r;
  logic [NUM_FEATURES-1:0] feat_r;
  logic [CCW-1:0]          n_r;
  logic [CCW-1:0]          c_r;
  logic [SCW-1:0]          s_r;
  logic [SCW-1:0]          cnt_r;
  logic [2:0]              pos_r;
  logic signed [3:0]       neg_r;
  logic signed [3:0]       res_r;
  logic                    out_valid_r;
  logic signed [3:0]       out_label_r;

  logic           in_acc;
  logic           is_cls;
  logic [CCW-1:0] n_clamp;
  logic [SCW-1:0] cnt_clamp;
  logic           st_we, hdr_we;
  stump_t         st_wdata, st_rdata;
  header_t        hdr_wdata, hdr_rdata;
  logic [SW-1:0]  rd_s;
  logic           feat_on;
  logic           plus;
  logic           fires;
  logic           last_c;
  logic           out_free;
  logic           vote_ok;
  acc_ctrl_t      acc_ctrl;
  vote_ctrl_t     vote_ctrl;
  logic [CLW-1:0] vote_label;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign is_cls    = in_acc && (in_req_type == REQ_CLASSIFY);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  assign n_clamp = (int'(num_r) > MAX_CLASSIFIERS) ? CCW'(MAX_CLASSIFIERS) : CCW'(num_r);

  assign st_we = in_acc && (in_req_type == REQ_STUMP) &&
                 (int'(in_classifier_index) < MAX_CLASSIFIERS) &&
                 (int'(in_stump_index) < MAX_STUMPS);
  assign hdr_we = in_acc && (in_req_type == REQ_HEADER) &&
                  (int'(in_classifier_index) < MAX_CLASSIFIERS);

  assign st_wdata  = '{feat: in_feature_index, pol: in_polarity, weight: in_stump_weight};
  assign hdr_wdata = '{count: in_stump_count, pos: in_positive_label, neg: in_negative_label};

  assign rd_s = (state_r == S_HWAIT) ? '0 : SW'(s_r + SCW'(1));

  bse_ram #(
    .WIDTH($bits(stump_t)),
    .DEPTH(2 ** (CW + SW))
  ) u_stump_ram (
    .clk  (clk),
    .we   (st_we),
    .waddr({CW'(in_classifier_index), SW'(in_stump_index)}),
    .wdata(st_wdata),
    .raddr({CW'(c_r), rd_s}),
    .rdata(st_rdata)
  );

  bse_ram #(
    .WIDTH($bits(header_t)),
    .DEPTH(2 ** CW)
  ) u_hdr_ram (
    .clk  (clk),
    .we   (hdr_we),
    .waddr(CW'(in_classifier_index)),
    .wdata(hdr_wdata),
    .raddr(CW'(c_r)),
    .rdata(hdr_rdata)
  );

  assign cnt_clamp = (int'(hdr_rdata.count) > MAX_STUMPS) ? SCW'(MAX_STUMPS)
                                                          : SCW'(hdr_rdata.count);

  assign feat_on = (int'(st_rdata.feat) < NUM_FEATURES) ? feat_r[FW'(st_rdata.feat)] : 1'b0;
  assign plus    = feat_on ^ st_rdata.pol;

  assign acc_ctrl = '{clr: (state_r == S_HWAIT), en: (state_r == S_RUN), sub: !plus};

  bse_acc #(
    .SUM_W(SUM_W)
  ) u_acc (
    .clk   (clk),
    .ctrl  (acc_ctrl),
    .weight(st_rdata.weight),
    .nonneg(fires)
  );

  assign vote_ok = fires ? (int'(pos_r) < NUM_CLASSES)
                         : (!neg_r[3] && (int'(neg_r[2:0]) < NUM_CLASSES));

  assign vote_ctrl = '{clr:   is_cls,
                       en:    (state_r == S_DECIDE) && (meth_r == METHOD_OVO) && vote_ok,
                       label: fires ? pos_r : neg_r[2:0]};

  bse_vote #(
    .NUM_CLASSES    (NUM_CLASSES),
    .MAX_CLASSIFIERS(MAX_CLASSIFIERS)
  ) u_vote (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (vote_ctrl),
    .best_label(vote_label)
  );

  assign last_c = ((c_r + CCW'(1)) == n_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (is_cls) begin
          if (n_clamp == '0) begin
            state_nxt = (method_r == METHOD_OVR) ? S_DONE : S_TALLY;
          end else begin
            state_nxt = S_HREQ;
          end
        end
      end
      S_HREQ: begin
        state_nxt = S_HWAIT;
      end
      S_HWAIT: begin
        state_nxt = (cnt_clamp == '0) ? S_DECIDE : S_RUN;
      end
      S_RUN: begin
        if ((s_r + SCW'(1)) == cnt_r) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (meth_r == METHOD_OVR && fires) begin
          state_nxt = S_DONE;
        end else if (last_c) begin
          state_nxt = (meth_r == METHOD_OVR) ? S_DONE : S_TALLY;
        end else begin
          state_nxt = S_HREQ;
        end
      end
      S_TALLY: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      method_r    <= METHOD_OVO;
      num_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_METHOD: method_r <= cfg_wdata[0];
          CFG_NUM:    num_r    <= cfg_wdata;
          default:    ;
        endcase
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (is_cls) begin
          feat_r <= in_feature_bits[NUM_FEATURES-1:0];
          meth_r <= method_r;
          n_r    <= n_clamp;
          c_r    <= '0;
          res_r  <= LABEL_NONE;
        end
      end
      S_HWAIT: begin
        cnt_r <= cnt_clamp;
        pos_r <= hdr_rdata.pos;
        neg_r <= hdr_rdata.neg;
        s_r   <= '0;
      end
      S_RUN: begin
        s_r <= s_r + SCW'(1);
      end
      S_DECIDE: begin
        if (meth_r == METHOD_OVR && fires) begin
          res_r <= {1'b0, pos_r};
        end
        if (!last_c) begin
          c_r <= c_r + CCW'(1);
        end
      end
      S_TALLY: begin
        res_r <= 4'(vote_label);
      end
      S_DONE: begin
        if (out_free) begin
          out_label_r <= res_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid           = out_valid_r;
  assign out_predicted_label = out_label_r;

endmodule
